### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked and disabled by an active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: always");

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same cycle");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");

`endif

### design/sipq_pkg.sv
// ----------------------------------------------------------------------------
// sipq_pkg
// shared types and constants of the sorted insert priority queue
// ----------------------------------------------------------------------------
package sipq_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMD_W  = 2;
    localparam int ID_W   = 16;
    localparam int KEY_W  = 16;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_entry;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DEQUEUE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     append;
        t_entry   entry;
    } t_cell_ctrl;

endpackage

### design/sipq_if.sv
// ----------------------------------------------------------------------------
// sipq_if
// valid/ready channels for commands and results
// ----------------------------------------------------------------------------
interface sipq_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [sipq_pkg::CMD_W-1:0]    command;
    logic [sipq_pkg::ID_W-1:0]     entry_id;
    logic [sipq_pkg::KEY_W-1:0]    wingspan_key;

    modport source (output valid, command, entry_id, wingspan_key, input ready);
    modport sink   (input valid, command, entry_id, wingspan_key, output ready);
endinterface

interface sipq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sipq_pkg::ID_W-1:0]     head_id;
    logic [sipq_pkg::KEY_W-1:0]    head_key;
    logic [sipq_pkg::STAT_W-1:0]   status;
    logic [sipq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, head_id, head_key, status, occupancy, input ready);
    modport sink   (input valid, head_id, head_key, status, occupancy, output ready);
endinterface

### design/sipq_cell.sv
// ----------------------------------------------------------------------------
// sipq_cell
// one queue slot: holds, loads the new entry, or takes a neighbor's entry
// ----------------------------------------------------------------------------
module sipq_cell (
    input  logic                 i_clk,
    input  sipq_pkg::t_cell_ctrl i_ctrl,
    input  sipq_pkg::t_entry     i_left,
    input  sipq_pkg::t_entry     i_right,
    input  logic                 i_occ,
    input  logic                 i_match_prev,
    output logic                 o_match,
    output sipq_pkg::t_entry     o_entry
);

    sipq_pkg::t_entry r_entry;
    sipq_pkg::t_entry n_entry;
    logic             w_hit;

    // first free slot, or, for a keyed insert, first stored key not above the new key
    assign w_hit   = !i_occ || (!i_ctrl.append && (r_entry.key <= i_ctrl.entry.key));
    assign o_match = i_match_prev | w_hit;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctrl.op)
            sipq_pkg::OP_INSERT: begin
                if (i_match_prev) begin
                    n_entry = i_left;
                end else if (w_hit) begin
                    n_entry = i_ctrl.entry;
                end
            end
            sipq_pkg::OP_DEQUEUE: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### design/sipq_chain.sv
// ----------------------------------------------------------------------------
// sipq_chain
// row of slot cells with a ripple match chain from head to tail
// ----------------------------------------------------------------------------
module sipq_chain (
    input  logic                       i_clk,
    input  sipq_pkg::t_cell_ctrl       i_ctrl,
    input  logic [sipq_pkg::DEPTH-1:0] i_occ,
    output sipq_pkg::t_entry           o_head
);

    sipq_pkg::t_entry             w_entry [sipq_pkg::DEPTH];
    logic [sipq_pkg::DEPTH:0]     w_match;

    assign w_match[0] = 1'b0;
    assign o_head     = w_entry[0];

    for (genvar g = 0; g < sipq_pkg::DEPTH; g++) begin : g_cell
        sipq_pkg::t_entry w_left;
        sipq_pkg::t_entry w_right;

        if (g == 0) begin : g_first
            assign w_left = i_ctrl.entry;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end

        if (g == sipq_pkg::DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end

        sipq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_left       (w_left),
            .i_right      (w_right),
            .i_occ        (i_occ[g]),
            .i_match_prev (w_match[g]),
            .o_match      (w_match[g+1]),
            .o_entry      (w_entry[g])
        );
    end

endmodule

### design/sorted_insert_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// bounded queue with tail append, keyed insert and head removal
// ----------------------------------------------------------------------------
// a result is registered at its command transfer and is valid in the following cycle
// throughput: one command per cycle while results are drained without stall;
// the command side takes a transfer whenever the result register is free or drained
// reset clears the entry count and the result valid; slot contents stay undefined
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_insert_priority_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sipq_cmd_if.sink   i_cmd,
    sipq_rsp_if.source o_rsp
);

    logic [sipq_pkg::CNT_W-1:0]  r_count;
    logic [sipq_pkg::CNT_W-1:0]  n_count;
    logic                        r_out_valid;
    logic                        n_out_valid;
    logic [sipq_pkg::ID_W-1:0]   r_head_id;
    logic [sipq_pkg::ID_W-1:0]   n_head_id;
    logic [sipq_pkg::KEY_W-1:0]  r_head_key;
    logic [sipq_pkg::KEY_W-1:0]  n_head_key;
    logic [sipq_pkg::STAT_W-1:0] r_status;
    logic [sipq_pkg::STAT_W-1:0] n_status;

    logic                        w_accept;
    logic                        w_full;
    logic                        w_empty;
    logic [sipq_pkg::DEPTH-1:0]  w_occ;
    sipq_pkg::t_cell_ctrl        w_ctrl;
    sipq_pkg::t_entry            w_head;

    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_full      = (r_count == sipq_pkg::CNT_W'(sipq_pkg::DEPTH));
    assign w_empty     = (r_count == '0);

    for (genvar g = 0; g < sipq_pkg::DEPTH; g++) begin : g_occ
        assign w_occ[g] = (sipq_pkg::CNT_W'(g) < r_count);
    end

    sipq_chain u_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_occ  (w_occ),
        .o_head (w_head)
    );

    always_comb begin
        w_ctrl.op        = sipq_pkg::OP_HOLD;
        w_ctrl.append    = (i_cmd.command == sipq_pkg::CMD_APPEND);
        w_ctrl.entry.id  = i_cmd.entry_id;
        w_ctrl.entry.key = i_cmd.wingspan_key;
        n_count          = r_count;
        n_out_valid      = r_out_valid && !o_rsp.ready;
        n_head_id        = r_head_id;
        n_head_key       = r_head_key;
        n_status         = r_status;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_head_id   = '0;
            n_head_key  = '0;
            n_status    = sipq_pkg::ST_OK;
            case (i_cmd.command)
                sipq_pkg::CMD_APPEND, sipq_pkg::CMD_INSERT: begin
                    if (w_full) begin
                        n_status = sipq_pkg::ST_FULL;
                    end else begin
                        w_ctrl.op = sipq_pkg::OP_INSERT;
                        n_count   = r_count + 1'b1;
                    end
                end
                sipq_pkg::CMD_DEQUEUE: begin
                    if (w_empty) begin
                        n_status = sipq_pkg::ST_EMPTY;
                    end else begin
                        w_ctrl.op  = sipq_pkg::OP_DEQUEUE;
                        n_count    = r_count - 1'b1;
                        n_head_id  = w_head.id;
                        n_head_key = w_head.key;
                    end
                end
                default: begin
                    n_status = sipq_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_head_id  <= n_head_id;
        r_head_key <= n_head_key;
        r_status   <= n_status;
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.head_id   = r_head_id;
    assign o_rsp.head_key  = r_head_key;
    assign o_rsp.status    = r_status;
    assign o_rsp.occupancy = sipq_pkg::OCC_W'(r_count);

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= sipq_pkg::CNT_W'(sipq_pkg::DEPTH))
    `ASSERT_NEXT(a_count_stable, i_clk, i_rst_n, i_rst_n && !w_accept, $stable(r_count))
    `ASSERT_NEXT(a_empty_status, i_clk, i_rst_n, i_rst_n && w_accept && w_empty && (i_cmd.command == sipq_pkg::CMD_DEQUEUE), r_out_valid && (r_status == sipq_pkg::ST_EMPTY) && (r_count == '0))
    `ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, i_rst_n && w_accept && !w_full && ((i_cmd.command == sipq_pkg::CMD_APPEND) || (i_cmd.command == sipq_pkg::CMD_INSERT)), r_count == $past(r_count) + 1'b1)

endmodule
